>>> src/hptc_pkg.sv
// ---------------------------------------------------------------------------
// Compensation package
// Shared types, calibration layout and shift helpers for the sensor
// compensation pipeline.
// ---------------------------------------------------------------------------
package hptc_pkg;

   // Number of quotient bits produced by the divider pipeline.
   localparam int DIV_STEPS = 64;

   // Calibration register file as held at the top level.
   typedef struct packed {
      logic [47:0] temp_cal;
      logic [47:0] press_cal_a;
      logic [47:0] press_cal_b;
      logic [47:0] press_cal_c;
      logic [39:0] hum_cal_a;
      logic [23:0] hum_cal_b;
   } cal_type;

   // Results that ride alongside the pressure division.
   typedef struct packed {
      logic [31:0] temp;
      logic [16:0] hum;
      logic        div_zero;
   } side_type;

   // One stage of the restoring divider: partial remainder, shifting
   // numerator/quotient word, divisor magnitude and result sign.
   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] nq;
      logic [63:0] den;
      logic        neg;
      side_type    side;
   } div_type;

   // One finished result.
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] press;
      logic [16:0] hum;
   } result_type;

   // Arithmetic right shift of a 32-bit word.
   function automatic logic [31:0] asr32(logic [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   // Arithmetic right shift of a 64-bit word.
   function automatic logic [63:0] asr64(logic [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

endpackage

>>> src/hptc_mul64.sv
// ---------------------------------------------------------------------------
// Pipelined 64-bit multiplier
// Two-stage multiplier that returns the low 64 bits of a 64 by 64 product
// from three 32 by 32 partial products.
// ---------------------------------------------------------------------------
module hptc_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic [63:0] prod
);
   logic [63:0] lo_in, lo_ff;
   logic [31:0] mid0_in, mid0_ff;
   logic [31:0] mid1_in, mid1_ff;
   logic [63:0] prod_in, prod_ff;

   // Partial products; the cross terms only matter in their low half.
   assign lo_in   = {32'd0, op_a[31:0]} * {32'd0, op_b[31:0]};
   assign mid0_in = op_a[31:0] * op_b[63:32];
   assign mid1_in = op_a[63:32] * op_b[31:0];

   // Recombine the partial products.
   assign prod_in = lo_ff + {mid0_ff + mid1_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= lo_in;
         mid0_ff <= mid0_in;
         mid1_ff <= mid1_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule

>>> src/hptc_front.sv
// ---------------------------------------------------------------------------
// Compensation front end
// Fine temperature, temperature, humidity and the pressure terms up to the
// signed division operands, in eleven register stages.
// ---------------------------------------------------------------------------
module hptc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [19:0]       raw_pressure,
   input  logic [19:0]       raw_temperature,
   input  logic [15:0]       raw_humidity,
   input  hptc_pkg::cal_type cal,
   output logic              out_valid,
   output hptc_pkg::div_type out_data
);
   import hptc_pkg::*;

   logic [11:1]        vld_ff;
   logic [19:0]        ap_ff [1:3];
   logic [15:0]        ah_ff [1:4];

   // Stage 1 signals.
   logic signed [17:0] dt1_in;
   logic signed [16:0] dt2_in;
   logic signed [33:0] m1_in, sq_in;
   logic [31:0]        m1_ff, sq_ff;

   // Stage 2 and 3 signals.
   logic [31:0]        v1_in, v1_ff, sqs_in;
   logic signed [35:0] m3_in;
   logic [31:0]        m3_ff, tf_in, tf_ff;

   // Stage 4 signals.
   logic signed [32:0] a_in;
   logic signed [65:0] aa_in;
   logic [63:0]        aa_ff;
   logic signed [48:0] ap5_in, ap2_in;
   logic [48:0]        ap5_ff [4:6];
   logic [48:0]        ap2_ff [4:6];
   logic [20:0]        p0_in;
   logic [20:0]        p0_ff [4:7];
   logic [31:0]        temp_in;
   logic [31:0]        temp_ff [4:10];
   logic [31:0]        hv_in, h5v_in, h5v_ff, vh6_in, vh6_ff, vh3_in, vh3_ff;

   // Humidity stages.
   logic [31:0]        x_in, t6_in, t6_ff, t3h_in, t3h_ff;
   logic [31:0]        x_ff [5:7];
   logic [31:0]        y0_in, y0_ff, y2_in, y2_ff, yv_in, vv_in;
   logic [31:0]        vv_ff [8:10];
   logic [31:0]        s_in;
   logic signed [33:0] ss_in;
   logic [31:0]        ss_ff, w0_in, w0_ff, vh_in;
   logic [16:0]        hum_in;

   // Pressure stages.
   logic [63:0]        b1_mul, c1_mul, ma_mul, mp_mul;
   logic [63:0]        b_in, b_ff, a2p_in, a2p_ff, a2p8_ff, pd_in, pd_ff;
   logic [63:0]        a3_in;

   div_type            out_in, out_ff;

   // Temperature differences and their first products.
   assign dt1_in = $signed({1'b0, raw_temperature[19:3]})
                 - $signed({1'b0, cal.temp_cal[15:0], 1'b0});
   assign dt2_in = $signed({1'b0, raw_temperature[19:4]})
                 - $signed({1'b0, cal.temp_cal[15:0]});
   assign m1_in  = dt1_in * $signed(cal.temp_cal[31:16]);
   assign sq_in  = dt2_in * dt2_in;

   // Scale the two temperature terms.
   assign v1_in  = asr32(m1_ff, 11);
   assign sqs_in = asr32(sq_ff, 12);
   assign m3_in  = $signed(sqs_in[19:0]) * $signed(cal.temp_cal[47:32]);

   // Fine temperature.
   assign tf_in  = v1_ff + asr32(m3_ff, 14);

   // Temperature output and the first pressure and humidity terms.
   assign a_in    = $signed({tf_ff[31], tf_ff}) - 33'sd128000;
   assign aa_in   = a_in * a_in;
   assign ap5_in  = a_in * $signed(cal.press_cal_b[31:16]);
   assign ap2_in  = a_in * $signed(cal.press_cal_a[31:16]);
   assign p0_in   = 21'd1048576 - {1'b0, ap_ff[3]};
   assign temp_in = asr32((tf_ff << 2) + tf_ff + 32'd128, 8);
   assign hv_in   = tf_ff - 32'd76800;
   assign h5v_in  = hv_in * {20'd0, cal.hum_cal_b[23:12]};
   assign vh6_in  = hv_in * {{24{cal.hum_cal_a[39]}}, cal.hum_cal_a[39:32]};
   assign vh3_in  = hv_in * {24'd0, cal.hum_cal_a[31:24]};

   // Humidity chain.
   assign x_in   = asr32(({16'd0, ah_ff[4]} << 14)
                       - ({20'd0, cal.hum_cal_b[11:0]} << 20)
                       - h5v_ff + 32'd16384, 15);
   assign t6_in  = asr32(vh6_ff, 10);
   assign t3h_in = asr32(vh3_ff, 11) + 32'd32768;
   assign y0_in  = t6_ff * t3h_ff;
   assign y2_in  = (asr32(y0_ff, 10) + 32'd2097152)
                 * {{16{cal.hum_cal_a[23]}}, cal.hum_cal_a[23:8]};
   assign yv_in  = asr32(y2_ff + 32'd8192, 14);
   assign vv_in  = x_ff[7] * yv_in;
   assign s_in   = asr32(vv_ff[8], 15);
   assign ss_in  = $signed(s_in[16:0]) * $signed(s_in[16:0]);
   assign w0_in  = asr32(ss_ff, 7) * {24'd0, cal.hum_cal_a[7:0]};
   assign vh_in  = vv_ff[10] - asr32(w0_ff, 4);

   // Clamp humidity to the valid range and drop the low twelve bits.
   always_comb begin
      if (vh_in[31]) begin
         hum_in = '0;
      end else if (vh_in > 32'd419430400) begin
         hum_in = 17'd102400;
      end else begin
         hum_in = vh_in[28:12];
      end
   end

   // Pressure multiplies by the squared and scaled temperature terms.
   hptc_mul64 u_mul_b1 (
      .clock (clock),
      .en    (en),
      .op_a  (aa_ff),
      .op_b  ({{48{cal.press_cal_b[47]}}, cal.press_cal_b[47:32]}),
      .prod  (b1_mul)
   );

   hptc_mul64 u_mul_c1 (
      .clock (clock),
      .en    (en),
      .op_a  (aa_ff),
      .op_b  ({{48{cal.press_cal_a[47]}}, cal.press_cal_a[47:32]}),
      .prod  (c1_mul)
   );

   // Sum the divisor and dividend terms.
   assign b_in   = b1_mul + ({{15{ap5_ff[6][48]}}, ap5_ff[6]} << 17)
                 + ({{48{cal.press_cal_b[15]}}, cal.press_cal_b[15:0]} << 35);
   assign a2p_in = asr64(c1_mul, 8) + ({{15{ap2_ff[6][48]}}, ap2_ff[6]} << 12)
                 + 64'h0000_8000_0000_0000;
   assign pd_in  = {12'd0, p0_ff[7], 31'd0} - b_ff;

   hptc_mul64 u_mul_a3 (
      .clock (clock),
      .en    (en),
      .op_a  (a2p8_ff),
      .op_b  ({48'd0, cal.press_cal_a[15:0]}),
      .prod  (ma_mul)
   );

   hptc_mul64 u_mul_pd (
      .clock (clock),
      .en    (en),
      .op_a  (pd_ff),
      .op_b  (64'd3125),
      .prod  (mp_mul)
   );

   // Divider operands as magnitudes with the quotient sign.
   assign a3_in = asr64(ma_mul, 33);

   always_comb begin
      out_in.rem           = '0;
      out_in.nq            = mp_mul[63] ? (64'd0 - mp_mul) : mp_mul;
      out_in.den           = a3_in[63] ? (64'd0 - a3_in) : a3_in;
      out_in.neg           = mp_mul[63] ^ a3_in[63];
      out_in.side.temp     = temp_ff[10];
      out_in.side.hum      = hum_in;
      out_in.side.div_zero = (a3_in == 64'd0);
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[10:1], in_valid};
      end
   end

   // Datapath registers, all advancing together.
   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff    <= m1_in[31:0];
         sq_ff    <= sq_in[31:0];
         ap_ff[1] <= raw_pressure;
         ah_ff[1] <= raw_humidity;
         v1_ff    <= v1_in;
         m3_ff    <= m3_in[31:0];
         ap_ff[2] <= ap_ff[1];
         ah_ff[2] <= ah_ff[1];
         tf_ff    <= tf_in;
         ap_ff[3] <= ap_ff[2];
         ah_ff[3] <= ah_ff[2];
         aa_ff      <= aa_in[63:0];
         ap5_ff[4]  <= ap5_in;
         ap2_ff[4]  <= ap2_in;
         p0_ff[4]   <= p0_in;
         temp_ff[4] <= temp_in;
         h5v_ff     <= h5v_in;
         vh6_ff     <= vh6_in;
         vh3_ff     <= vh3_in;
         ah_ff[4]   <= ah_ff[3];
         x_ff[5]   <= x_in;
         t6_ff     <= t6_in;
         t3h_ff    <= t3h_in;
         y0_ff     <= y0_in;
         x_ff[6]   <= x_ff[5];
         y2_ff     <= y2_in;
         x_ff[7]   <= x_ff[6];
         ap5_ff[5] <= ap5_ff[4];
         ap5_ff[6] <= ap5_ff[5];
         ap2_ff[5] <= ap2_ff[4];
         ap2_ff[6] <= ap2_ff[5];
         p0_ff[5]  <= p0_ff[4];
         p0_ff[6]  <= p0_ff[5];
         p0_ff[7]  <= p0_ff[6];
         b_ff      <= b_in;
         a2p_ff    <= a2p_in;
         pd_ff     <= pd_in;
         a2p8_ff   <= a2p_ff;
         vv_ff[8]  <= vv_in;
         ss_ff     <= ss_in[31:0];
         vv_ff[9]  <= vv_ff[8];
         w0_ff     <= w0_in;
         vv_ff[10] <= vv_ff[9];
         for (int i = 5; i <= 10; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[11];
   assign out_data  = out_ff;
endmodule

>>> src/hptc_div.sv
// ---------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring division, one quotient bit per register stage, with
// the sign and side results carried along.
// ---------------------------------------------------------------------------
module hptc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  hptc_pkg::div_type in_data,
   output logic              out_valid,
   output hptc_pkg::div_type out_data
);
   import hptc_pkg::*;

   div_type              st_ff [0:DIV_STEPS-1];
   logic [DIV_STEPS-1:0] vld_ff;

   // One restoring step: bring in the next numerator bit, subtract the
   // divisor when it fits and shift the quotient bit in.
   function automatic div_type div_step(div_type x);
      div_type     r;
      logic [64:0] sh;
      r  = x;
      sh = {x.rem, x.nq[63]};
      r.nq = {x.nq[62:0], 1'b0};
      if (sh >= {1'b0, x.den}) begin
         r.rem   = sh[63:0] - x.den;
         r.nq[0] = 1'b1;
      end else begin
         r.rem = sh[63:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   // Step registers.
   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= div_step(in_data);
         for (int k = 1; k < DIV_STEPS; k++) begin
            st_ff[k] <= div_step(st_ff[k-1]);
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_data  = st_ff[DIV_STEPS-1];
endmodule

>>> src/hptc_back.sv
// ---------------------------------------------------------------------------
// Compensation back end
// Signs the quotient and applies the final pressure correction terms in
// eight register stages.
// ---------------------------------------------------------------------------
module hptc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  hptc_pkg::div_type    in_data,
   input  hptc_pkg::cal_type    cal,
   output logic                 out_valid,
   output hptc_pkg::result_type out_data
);
   import hptc_pkg::*;

   logic [8:1]  vld_ff;
   side_type    side_ff [1:7];
   logic [63:0] pv_in;
   logic [63:0] p_ff [1:6];
   logic [63:0] qv_in;
   logic [63:0] qv_ff [2:4];
   logic [63:0] m9_mul, m8_mul, mq_mul;
   logic [63:0] m8_ff [5:6];
   logic [63:0] sum_in, sum_ff, res_in;
   result_type  out_in, out_ff;

   // Signed quotient and its scaled copy.
   assign pv_in = in_data.neg ? (64'd0 - in_data.nq) : in_data.nq;
   assign qv_in = asr64(p_ff[1], 13);

   hptc_mul64 u_mul_p9 (
      .clock (clock),
      .en    (en),
      .op_a  ({{48{cal.press_cal_c[47]}}, cal.press_cal_c[47:32]}),
      .op_b  (qv_ff[2]),
      .prod  (m9_mul)
   );

   hptc_mul64 u_mul_p8 (
      .clock (clock),
      .en    (en),
      .op_a  ({{48{cal.press_cal_c[31]}}, cal.press_cal_c[31:16]}),
      .op_b  (p_ff[2]),
      .prod  (m8_mul)
   );

   hptc_mul64 u_mul_q (
      .clock (clock),
      .en    (en),
      .op_a  (m9_mul),
      .op_b  (qv_ff[4]),
      .prod  (mq_mul)
   );

   // Add the correction terms, then the offset coefficient.
   assign sum_in = p_ff[6] + asr64(mq_mul, 25) + asr64(m8_ff[6], 19);
   assign res_in = asr64(sum_ff, 8)
                 + ({{48{cal.press_cal_c[15]}}, cal.press_cal_c[15:0]} << 4);

   always_comb begin
      out_in.temp  = side_ff[7].temp;
      out_in.hum   = side_ff[7].hum;
      out_in.press = side_ff[7].div_zero ? 32'd0 : res_in[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= in_data.side;
         for (int i = 2; i <= 7; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         p_ff[1] <= pv_in;
         for (int i = 2; i <= 6; i++) begin
            p_ff[i] <= p_ff[i-1];
         end
         qv_ff[2] <= qv_in;
         qv_ff[3] <= qv_ff[2];
         qv_ff[4] <= qv_ff[3];
         m8_ff[5] <= m8_mul;
         m8_ff[6] <= m8_ff[5];
         sum_ff   <= sum_in;
         out_ff   <= out_in;
      end
   end

   assign out_valid = vld_ff[8];
   assign out_data  = out_ff;
endmodule

>>> src/humidity_pressure_temp_compensation_top.sv
// A request passes through 11 front stages, 64 divider stages and 8 back stages
// and then the output buffer before rsp_valid rises.
// Throughput: one request per cycle while the output buffer has room.
// The 64-stage divider is the longest part of the pipeline.
// A two-entry output buffer lets requests enter while a result waits.
// Reset clears the calibration registers and all valid bits.
// ---------------------------------------------------------------------------
// Sensor compensation top level
// Calibration registers, the compensation pipeline and the output buffer.
// ---------------------------------------------------------------------------
module humidity_pressure_temp_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_raw_pressure,
   input  logic [19:0] req_raw_temperature,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic [16:0] rsp_humidity_q22_10,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   import hptc_pkg::*;

   // Register indexes.
   localparam logic [2:0] CSR_TEMP_CAL    = 3'd0;
   localparam logic [2:0] CSR_PRESS_CAL_A = 3'd1;
   localparam logic [2:0] CSR_PRESS_CAL_B = 3'd2;
   localparam logic [2:0] CSR_PRESS_CAL_C = 3'd3;
   localparam logic [2:0] CSR_HUM_CAL_A   = 3'd4;
   localparam logic [2:0] CSR_HUM_CAL_B   = 3'd5;

   cal_type    cal_ff;
   logic       adv;
   logic       front_valid, div_valid, back_valid;
   div_type    front_data, div_data;
   result_type back_data;
   result_type buf_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   // Calibration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEMP_CAL:    cal_ff.temp_cal    <= csr_wdata;
            CSR_PRESS_CAL_A: cal_ff.press_cal_a <= csr_wdata;
            CSR_PRESS_CAL_B: cal_ff.press_cal_b <= csr_wdata;
            CSR_PRESS_CAL_C: cal_ff.press_cal_c <= csr_wdata;
            CSR_HUM_CAL_A:   cal_ff.hum_cal_a   <= csr_wdata[39:0];
            CSR_HUM_CAL_B:   cal_ff.hum_cal_b   <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline advances while the output buffer has room.
   assign adv       = (count_ff != 2'd2);
   assign req_ready = adv;

   hptc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (adv),
      .in_valid        (req_valid),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .raw_humidity    (req_raw_humidity),
      .cal             (cal_ff),
      .out_valid       (front_valid),
      .out_data        (front_data)
   );

   hptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   hptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .cal       (cal_ff),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   // Two-entry output buffer.
   assign push = adv & back_valid;
   assign pop  = rsp_valid & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= back_data;
      end
   end

   assign rsp_valid             = (count_ff != 2'd0);
   assign rsp_temperature_centi = buf_ff[rd_ptr_ff].temp;
   assign rsp_pressure_q24_8    = buf_ff[rd_ptr_ff].press;
   assign rsp_humidity_q22_10   = buf_ff[rd_ptr_ff].hum;
endmodule

>>> verif/humidity_pressure_temp_compensation_top_test.sv
// ---------------------------------------------------------------------------
// Sensor compensation testbench
// Drives raw temperature/pressure/humidity requests through the pipeline
// under several calibration settings and handshake idling patterns. An
// in-bench compensation predictor produces the expected readings, and the
// monitor checks every response against them in order.
// ---------------------------------------------------------------------------
module humidity_pressure_temp_compensation_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Calibration register indexes on the write port.
   typedef enum logic [2:0] {
      REG_TEMP_CAL, REG_PRESS_CAL_A, REG_PRESS_CAL_B, REG_PRESS_CAL_C,
      REG_HUM_CAL_A, REG_HUM_CAL_B, REG_SPARE_6, REG_SPARE_7
   } cal_index_type;

   typedef struct {
      logic [19:0] raw_press;
      logic [19:0] raw_temp;
      logic [15:0] raw_hum;
   } sample_type;

   typedef struct {
      logic [31:0] temp;
      logic [31:0] press;
      logic [16:0] hum;
   } reading_type;

   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [19:0] req_raw_pressure = '0;
   logic [19:0] req_raw_temperature = '0;
   logic [15:0] req_raw_humidity = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_q24_8;
   logic [16:0] rsp_humidity_q22_10;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   // Calibration copy kept by the bench.
   logic [47:0] cal_temp = '0, cal_press_a = '0, cal_press_b = '0, cal_press_c = '0;
   logic [39:0] cal_hum_a = '0;
   logic [23:0] cal_hum_b = '0;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          mismatches = 0;
   int          checked = 0;
   int          zero_div_seen = 0;
   int          cycles = 0;

   humidity_pressure_temp_compensation_top dut (.*);

   // Clock; the single reset pulse is released by the stimulus sequence.
   initial begin
      forever #5 clock = ~clock;
   end

   // Arithmetic right shifts that stay arithmetic inside larger expressions.
   function automatic logic [31:0] sra32(logic [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] sra64(logic [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   // Integer compensation of one raw triple under the current calibration.
   function automatic reading_type compensate(sample_type s);
      reading_type r;
      logic [31:0] at, ah, t1, t2, t3, v1, dt, v2, tf;
      logic [31:0] h1, h2, h3, h4, h5, h6, hv, hx, hy, hs, hw;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q, an, ad;
      logic        nn, dn;
      at = {12'd0, s.raw_temp};
      ah = {16'd0, s.raw_hum};
      // Fine temperature.
      t1 = {16'd0, cal_temp[15:0]};
      t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
      t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
      v1 = $signed(((at >> 3) - (t1 << 1)) * t2) >>> 11;
      dt = (at >> 4) - t1;
      v2 = sra32(sra32(dt * dt, 12) * t3, 14);
      tf = v1 + v2;
      r.temp = $signed(tf * 32'd5 + 32'd128) >>> 8;
      // Pressure in 64-bit wrapping arithmetic.
      p1 = {48'd0, cal_press_a[15:0]};
      p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
      p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
      p4 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
      p5 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
      p6 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
      p7 = {{48{cal_press_c[15]}}, cal_press_c[15:0]};
      p8 = {{48{cal_press_c[31]}}, cal_press_c[31:16]};
      p9 = {{48{cal_press_c[47]}}, cal_press_c[47:32]};
      a = {{32{tf[31]}}, tf} - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = sra64(a * a * p3, 8) + ((a * p2) << 12);
      a = $signed(((64'd1 << 47) + a) * p1) >>> 33;
      if (a == 64'd0) begin
         r.press = '0;
      end else begin
         p = 64'd1048576 - {44'd0, s.raw_press};
         p = ((p << 31) - b) * 64'd3125;
         // Signed division truncating toward zero; the overflow case wraps.
         nn = p[63];
         dn = a[63];
         an = nn ? -p : p;
         ad = dn ? -a : a;
         q = an / ad;
         p = (nn != dn) ? -q : q;
         q = $signed(p) >>> 13;
         a = $signed(p9 * q * q) >>> 25;
         b = $signed(p8 * p) >>> 19;
         p = sra64(p + a + b, 8) + (p7 << 4);
         r.press = p[31:0];
      end
      // Humidity in 32-bit wrapping arithmetic, clamped before the last shift.
      h1 = {24'd0, cal_hum_a[7:0]};
      h2 = {{16{cal_hum_a[23]}}, cal_hum_a[23:8]};
      h3 = {24'd0, cal_hum_a[31:24]};
      h6 = {{24{cal_hum_a[39]}}, cal_hum_a[39:32]};
      h4 = {20'd0, cal_hum_b[11:0]};
      h5 = {20'd0, cal_hum_b[23:12]};
      hv = tf - 32'd76800;
      hx = $signed((ah << 14) - (h4 << 20) - h5 * hv + 32'd16384) >>> 15;
      hy = sra32(hv * h6, 10) * (sra32(hv * h3, 11) + 32'd32768);
      hy = sra32(hy, 10) + 32'd2097152;
      hy = $signed(hy * h2 + 32'd8192) >>> 14;
      hv = hx * hy;
      hs = $signed(hv) >>> 15;
      hw = sra32(sra32(hs * hs, 7) * h1, 4);
      hv = hv - hw;
      if (hv[31]) hv = '0;
      else if (hv > 32'd419430400) hv = 32'd419430400;
      r.hum = hv[28:12];
      return r;
   endfunction

   // Request driver: holds a request until accepted, idles at random.
   always @(posedge clock) begin
      sample_type  s;
      reading_type e;
      logic        busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid && !req_ready;
         if (!busy) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               s = pending_samples.pop_front();
               e = compensate(s);
               if (cal_press_a[15:0] == 16'd0) zero_div_seen++;
               expected_readings.push_back(e);
               req_raw_pressure <= s.raw_press;
               req_raw_temperature <= s.raw_temp;
               req_raw_humidity <= s.raw_hum;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random back-pressure and in-order checking.
   always @(posedge clock) begin
      reading_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response: temp %h press %h hum %h",
                  rsp_temperature_centi, rsp_pressure_q24_8, rsp_humidity_q22_10);
            end else begin
               e = expected_readings.pop_front();
               checked++;
               if (rsp_temperature_centi !== e.temp || rsp_pressure_q24_8 !== e.press ||
                   rsp_humidity_q22_10 !== e.hum) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch #%0d: temp %h/%h press %h/%h hum %h/%h (exp/act)",
                        checked, e.temp, rsp_temperature_centi, e.press,
                        rsp_pressure_q24_8, e.hum, rsp_humidity_q22_10);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_cal(cal_index_type idx, logic [47:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_TEMP_CAL:    cal_temp <= data;
         REG_PRESS_CAL_A: cal_press_a <= data;
         REG_PRESS_CAL_B: cal_press_b <= data;
         REG_PRESS_CAL_C: cal_press_c <= data;
         REG_HUM_CAL_A:   cal_hum_a <= data[39:0];
         REG_HUM_CAL_B:   cal_hum_b <= data[23:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait for the pipeline to empty, then let it settle.
   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_readings.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_sample(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
      sample_type s;
      s.raw_press = rp;
      s.raw_temp = rt;
      s.raw_hum = rh;
      pending_samples.push_back(s);
   endtask

   task automatic add_random(int count);
      repeat (count) begin
         if ($urandom_range(3) == 0)
            add_sample($urandom, $urandom, $urandom);
         else
            add_sample($urandom_range(500000, 300000), $urandom_range(560000, 450000),
                       $urandom_range(45000, 15000));
      end
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 49; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 49; end
         default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
   endtask

   task automatic write_all(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc, logic [47:0] ha, logic [47:0] hb);
      write_cal(REG_TEMP_CAL, tc);
      write_cal(REG_PRESS_CAL_A, pa);
      write_cal(REG_PRESS_CAL_B, pb);
      write_cal(REG_PRESS_CAL_C, pc);
      write_cal(REG_HUM_CAL_A, ha);
      write_cal(REG_HUM_CAL_B, hb);
   endtask

   // Stimulus sequence.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset calibration: pressure divisor is zero.
      add_sample(20'd0, 20'd0, 16'd0);
      add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      add_random(60);
      drain();

      // Typical datasheet-like calibration with directed extremes.
      write_all({16'hFC18, 16'd26435, 16'd27504},
                {16'd3024, 16'hD643, 16'd36477},
                {-16'sd7, 16'd140, 16'd2855},
                {16'd6000, -16'sd14600, 16'd15500},
                {8'd30, 8'd0, 16'd362, 8'd75},
                {12'd50, 12'd313});
      // Writes to unused indexes must be ignored.
      write_cal(REG_SPARE_6, 48'hFFFF_FFFF_FFFF);
      write_cal(REG_SPARE_7, 48'h1234_5678_9ABC);
      add_sample(20'd415148, 20'd519888, 16'd30000);
      add_sample(20'd0, 20'd519888, 16'd0);
      add_sample(20'hFFFFF, 20'd519888, 16'hFFFF);
      add_sample(20'd415148, 20'd0, 16'd30000);
      add_sample(20'd415148, 20'hFFFFF, 16'd30000);
      add_sample(20'd0, 20'd0, 16'd0);
      add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      add_sample(20'h80000, 20'h80000, 16'h8000);
      add_sample(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
      add_sample(20'd300000, 20'd440064, 16'd20000);
      add_sample(20'd500000, 20'd600000, 16'd50000);
      add_sample(20'd415148, 20'd519888, 16'd1);
      for (int m = 0; m < 4; m++) begin
         set_idling(m);
         add_random(40);
         drain();
      end

      // All ones, signed minimums, then random calibrations.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_all('1, '1, '1, '1, '1, '1);
            1: write_all(48'h8000_8000_0000, 48'h8000_8000_FFFF, 48'h8000_8000_8000,
                         48'h8000_8000_8000, 48'h80_FF_8000_FF, 48'hFFF_FFF);
            default: write_all({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom});
         endcase
         set_idling(ph + 1);
         add_random(50);
         drain();
         set_idling(ph);
         add_random(25);
         drain();
      end

      $display("Checked %0d responses over eight calibration settings and four idling patterns;",
               checked);
      $display("%0d requests ran with a zero pressure divisor, %0d mismatches.",
               zero_div_seen, mismatches);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
